// ----- rtl/fqs_pkg.sv -----
// Package for the FIFO queue with search: shared types, codes and constants.
// Used by fqs_store and fifo_queue_with_search_unit; depends on nothing.
package fqs_pkg;

    // Default queue depth and the most results a search or a list gives.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int RESULT_LIMIT    = 16;

    // Operation codes carried on the input tuser.
    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SIZE   = 3'd3,
        OP_SEARCH = 3'd4,
        OP_LIST   = 3'd5
    } t_opcode;

    // Result status codes carried on the output tuser.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_FLUSH
    } t_state;

    // One stored queue entry.
    typedef struct packed {
        logic signed [31:0] code;
        logic [63:0]        name_lo;
        logic [7:0]         name_hi;
    } t_entry;

    // One result, without the occupancy and the last marker.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] code;
        logic [63:0]        name_lo;
        logic [7:0]         name_hi;
        logic [3:0]         position;
    } t_result;

    // Zero the first null byte of a name and every byte after it.
    // Returns character 8 in bits 71:64 and characters 0 to 7 below.
    function automatic logic [71:0] clean_name(logic [63:0] lo, logic [7:0] hi);
        logic        ended;
        logic [71:0] res;
        ended = 1'b0;
        res   = '0;
        for (int k = 0; k < 8; k++) begin
            if (lo[8*k +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                res[8*k +: 8] = lo[8*k +: 8];
            end
        end
        if (!ended) begin
            res[71:64] = hi;
        end
        return res;
    endfunction

endpackage

// ----- rtl/fqs_store.sv -----
// Entry storage of the queue: one write port and one registered read port.
// Depends on fqs_pkg for the entry type.
module fqs_store
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    input  t_entry                         i_wr_data,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    output t_entry                         o_rd_data
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/fifo_queue_with_search_unit.sv -----
// Enqueue, clear and size pass through the pending result register and the flush
// state into the output register; dequeue first reads the entry store in the dequeue
// state, and search and list walk up to the occupancy in the scan state. Input is taken
// only in the idle state, so one transaction at a time; the single read port of the entry
// store and the shared code comparator walk one entry a cycle unless a hit waits on a stalled output.
// Reset (synchronous, active low) empties the queue; stored entries are not cleared.
module fifo_queue_with_search_unit
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // item_code[31:0], name_low[95:32], name_high[103:96]
    input  logic [2:0]   s_axis_tuser,  // opcode[2:0]
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // out_code[31:0], out_name_low[95:32],
                                        // out_name_high[103:96], position[107:104],
                                        // occupancy[112:108], zero fill[119:113]
    output logic [1:0]   m_axis_tuser,  // status[1:0]
    output logic         m_axis_tlast   // last_result
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(RESULT_LIMIT + 1);

    // Control and payload registers.
    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [PW-1:0]         r_ptr, n_ptr;
    logic [PW-1:0]         r_idx, n_idx;
    logic [NW-1:0]         r_nres, n_nres;
    logic signed [31:0]    r_key, n_key;
    logic                  r_is_list, n_is_list;
    t_result               r_pend, n_pend;
    logic                  r_pend_vld, n_pend_vld;
    t_result               r_out;
    logic [4:0]            r_out_occ;
    logic                  r_out_last;
    logic                  r_out_vld;

    // Internal signals.
    t_opcode               w_op;
    t_entry                w_in_entry;
    t_entry                w_rd;
    logic [71:0]           w_clean;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_hit;
    logic                  w_stall;
    logic                  w_done;
    logic                  w_wr_en;
    logic                  w_emit;
    logic                  w_emit_last;
    t_result               w_emit_res;
    logic [PW-1:0]         w_head_next;
    logic [PW-1:0]         w_tail_next;
    logic [PW-1:0]         w_ptr_next;

    // Input unpacking and handshake.
    assign w_op             = t_opcode'(s_axis_tuser);
    assign w_clean          = clean_name(s_axis_tdata[95:32], s_axis_tdata[103:96]);
    assign w_in_entry.code    = s_axis_tdata[31:0];
    assign w_in_entry.name_lo = w_clean[63:0];
    assign w_in_entry.name_hi = w_clean[71:64];
    assign s_axis_tready    = (r_state == S_IDLE);
    assign w_accept         = s_axis_tvalid && s_axis_tready;
    assign w_out_free       = !r_out_vld || m_axis_tready;

    // Ring pointer increments.
    assign w_head_next = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_tail_next = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);
    assign w_ptr_next  = (r_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_ptr + PW'(1);

    // Shared compare unit: one entry per scan cycle, unless a hit waits on a stalled output.
    assign w_hit   = r_is_list || (w_rd.code == r_key);
    assign w_stall = w_hit && r_pend_vld && !w_out_free;
    assign w_done  = ((CW'(r_idx) + CW'(1)) == r_count)
                  || (w_hit && (r_nres == NW'(RESULT_LIMIT - 1)));

    // Entry storage.
    fqs_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_in_entry),
        .i_rd_addr (n_ptr),
        .o_rd_data (w_rd)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_ENQ, OP_CLEAR, OP_SIZE: n_state = S_FLUSH;
                        OP_DEQ: n_state = (r_count == '0) ? S_FLUSH : S_DEQ;
                        OP_SEARCH, OP_LIST: n_state = (r_count == '0) ? S_FLUSH : S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DEQ: n_state = S_FLUSH;
            S_SCAN: begin
                if (!w_stall && w_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output control of the sequencer.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_nres      = r_nres;
        n_key       = r_key;
        n_is_list   = r_is_list;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        w_wr_en     = 1'b0;
        w_emit      = 1'b0;
        w_emit_last = 1'b0;
        w_emit_res  = r_pend;
        case (r_state)
            S_IDLE: begin
                n_ptr = r_head;
                if (w_accept) begin
                    n_pend     = '0;
                    n_pend_vld = 1'b1;
                    case (w_op)
                        OP_ENQ: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_pend.status = ST_FULL;
                            end else begin
                                w_wr_en         = 1'b1;
                                n_pend.status   = ST_OK;
                                n_pend.code     = w_in_entry.code;
                                n_pend.name_lo  = w_in_entry.name_lo;
                                n_pend.name_hi  = w_in_entry.name_hi;
                                n_pend.position = 4'(r_count);
                                n_tail          = w_tail_next;
                                n_count         = r_count + CW'(1);
                            end
                        end
                        OP_DEQ: begin
                            if (r_count == '0) begin
                                n_pend.status = ST_EMPTY;
                            end else begin
                                n_head  = w_head_next;
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        OP_SIZE: begin
                            n_pend.status = (r_count == '0) ? ST_EMPTY : ST_OK;
                        end
                        OP_SEARCH, OP_LIST: begin
                            if (r_count == '0) begin
                                n_pend.status = ST_EMPTY;
                            end else begin
                                n_pend_vld = 1'b0;
                                n_idx      = '0;
                                n_nres     = '0;
                                n_key      = s_axis_tdata[31:0];
                                n_is_list  = (w_op == OP_LIST);
                            end
                        end
                        default: begin
                            n_pend_vld = r_pend_vld;
                            n_pend     = r_pend;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_pend.status   = ST_OK;
                n_pend.code     = w_rd.code;
                n_pend.name_lo  = w_rd.name_lo;
                n_pend.name_hi  = w_rd.name_hi;
                n_pend.position = '0;
                n_pend_vld      = 1'b1;
            end
            S_SCAN: begin
                if (!w_stall) begin
                    if (w_hit) begin
                        // The previous hit is now known not to be the final one.
                        w_emit          = r_pend_vld;
                        n_pend.status   = ST_OK;
                        n_pend.code     = w_rd.code;
                        n_pend.name_lo  = w_rd.name_lo;
                        n_pend.name_hi  = w_rd.name_hi;
                        n_pend.position = 4'(r_idx);
                        n_pend_vld      = 1'b1;
                        n_nres          = r_nres + NW'(1);
                    end
                    if (!w_done) begin
                        n_idx = r_idx + PW'(1);
                        n_ptr = w_ptr_next;
                    end
                end
            end
            S_FLUSH: begin
                // Final result: the held one, or a not-found result for a search.
                w_emit      = 1'b1;
                w_emit_last = 1'b1;
                if (!r_pend_vld) begin
                    w_emit_res        = '0;
                    w_emit_res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_pend_vld = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_nres     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_nres     <= n_nres;
            r_pend_vld <= n_pend_vld;
            if (w_emit && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_key     <= n_key;
        r_is_list <= n_is_list;
        r_pend    <= n_pend;
        if (w_emit && w_out_free) begin
            r_out      <= w_emit_res;
            r_out_occ  <= 5'(r_count);
            r_out_last <= w_emit_last;
        end
    end

    // Output stream packing.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_occ, r_out.position, r_out.name_hi,
                            r_out.name_lo, r_out.code};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out_last;

    // The occupancy never exceeds the queue depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    // An empty or a full ring has its head and tail on the same slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(QUEUE_DEPTH)) |-> (r_head == r_tail))
        else $error("Head and tail pointers disagree with the entry count.");

    // A dequeue transaction on a non-empty queue removes exactly one entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == OP_DEQ && r_count != '0)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("Dequeue did not remove one entry.");

    // A scan never holds more than the result limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_nres < NW'(RESULT_LIMIT)))
        else $error("Scan passed the result limit.");

    // Every final result sent from the flush state closes the operation.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && w_out_free) |=> (r_out_vld && r_out_last && r_state == S_IDLE))
        else $error("Final result was not marked last.");

endmodule

// ----- verif/tb_fifo_queue_with_search_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_search_unit: directed and random queue
// commands, an in-bench model of the ring queue, and an in-order reply checker.
// Depends on fqs_pkg and the unit's RTL only.
module tb_fifo_queue_with_search_unit;
    import fqs_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;
    // Opcodes the unit has no use for; it must drop them silently.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // Kinds of command bursts in the random part.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // One command as offered on the input stream.
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] code;
        logic [63:0]        nlo;
        logic [7:0]         nhi;
    } queue_cmd_t;

    // One reply as seen on the output stream.
    typedef struct {
        t_status            status;
        logic signed [31:0] code;
        logic [63:0]        nlo;
        logic [7:0]         nhi;
        logic [3:0]         pos;
        logic [4:0]         occ;
        logic               last;
    } queue_reply_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;   // item_code, name_low, name_high
    logic [2:0]   s_axis_tuser = '0;   // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;        // out_code, out_name_low, out_name_high,
                                       // position, occupancy, zero fill
    logic [1:0]   m_axis_tuser;        // status
    logic         m_axis_tlast;        // last_result

    queue_cmd_t   cmd_backlog[$];
    queue_reply_t pending_replies[$];
    int           send_idle_pct = 16;
    int           recv_idle_pct = 80;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic         in_fire = 1'b0;
    logic         hold_req = 1'b0;
    logic         hold_ack = 1'b0;
    int           hold_left = 0;

    // Shadow copy of the queue contents and pointers.
    logic signed [31:0] shadow_code[DEPTH];
    logic [63:0]        shadow_nlo[DEPTH];
    logic [7:0]         shadow_nhi[DEPTH];
    int                 head_idx = 0;
    int                 tail_idx = 0;
    int                 fill_count = 0;

    fifo_queue_with_search_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Name as stored: a zero byte ends the name, so it and all later bytes read as zero.
    // Character 8 comes back in bits 71:64.
    function automatic logic [71:0] terminated_name(logic [63:0] lo, logic [7:0] hi);
        logic [71:0] raw;
        int          len;
        raw = {hi, lo};
        len = 9;
        for (int b = 8; b >= 0; b--) begin
            if (raw[8*b +: 8] == 8'd0) begin
                len = b;
            end
        end
        for (int b = len; b < 9; b++) begin
            raw[8*b +: 8] = 8'd0;
        end
        return raw;
    endfunction

    // Queue one expected reply; occupancy is taken from the shadow state as it is now.
    task automatic post_reply(t_status st, logic signed [31:0] c, logic [63:0] lo,
                              logic [7:0] hi, int pos, logic last);
        queue_reply_t r;
        r.status = st;
        r.code   = c;
        r.nlo    = lo;
        r.nhi    = hi;
        r.pos    = pos[3:0];
        r.occ    = fill_count[4:0];
        r.last   = last;
        pending_replies.push_back(r);
    endtask

    // Apply one accepted command to the shadow queue and queue the replies it causes.
    task automatic predict_queue_op(logic [2:0] op, logic signed [31:0] code,
                                    logic [63:0] nlo, logic [7:0] nhi);
        logic [71:0] kept;
        int          slot;
        int          hits;
        int          shown;
        int          walk;
        case (op)
            OP_ENQ: begin
                if (fill_count >= DEPTH) begin
                    post_reply(ST_FULL, '0, '0, '0, 0, 1'b1);
                end else begin
                    kept = terminated_name(nlo, nhi);
                    slot = tail_idx;
                    shadow_code[slot] = code;
                    shadow_nlo[slot]  = kept[63:0];
                    shadow_nhi[slot]  = kept[71:64];
                    tail_idx   = (tail_idx + 1) % DEPTH;
                    fill_count = fill_count + 1;
                    post_reply(ST_OK, code, kept[63:0], kept[71:64], fill_count - 1, 1'b1);
                end
            end
            OP_DEQ: begin
                if (fill_count == 0) begin
                    post_reply(ST_EMPTY, '0, '0, '0, 0, 1'b1);
                end else begin
                    slot       = head_idx;
                    head_idx   = (head_idx + 1) % DEPTH;
                    fill_count = fill_count - 1;
                    post_reply(ST_OK, shadow_code[slot], shadow_nlo[slot], shadow_nhi[slot],
                               0, 1'b1);
                end
            end
            OP_CLEAR: begin
                head_idx   = 0;
                tail_idx   = 0;
                fill_count = 0;
                post_reply(ST_OK, '0, '0, '0, 0, 1'b1);
            end
            OP_SIZE: begin
                post_reply(fill_count == 0 ? ST_EMPTY : ST_OK, '0, '0, '0, 0, 1'b1);
            end
            OP_SEARCH: begin
                // Count the reported matches first so the final one can carry tlast.
                hits = 0;
                walk = (fill_count < RESULT_LIMIT) ? fill_count : RESULT_LIMIT;
                for (int i = 0; i < fill_count; i++) begin
                    if (shadow_code[(head_idx + i) % DEPTH] == code) begin
                        hits++;
                    end
                end
                if (hits > RESULT_LIMIT) begin
                    hits = RESULT_LIMIT;
                end
                if (fill_count == 0) begin
                    post_reply(ST_EMPTY, '0, '0, '0, 0, 1'b1);
                end else if (hits == 0) begin
                    post_reply(ST_NOT_FOUND, '0, '0, '0, 0, 1'b1);
                end else begin
                    shown = 0;
                    for (int i = 0; i < fill_count && shown < hits; i++) begin
                        slot = (head_idx + i) % DEPTH;
                        if (shadow_code[slot] == code) begin
                            shown++;
                            post_reply(ST_OK, shadow_code[slot], shadow_nlo[slot],
                                       shadow_nhi[slot], i, shown == hits);
                        end
                    end
                end
            end
            OP_LIST: begin
                walk = (fill_count < RESULT_LIMIT) ? fill_count : RESULT_LIMIT;
                if (fill_count == 0) begin
                    post_reply(ST_EMPTY, '0, '0, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < walk; i++) begin
                        slot = (head_idx + i) % DEPTH;
                        post_reply(ST_OK, shadow_code[slot], shadow_nlo[slot],
                                   shadow_nhi[slot], i, i == walk - 1);
                    end
                end
            end
            default: begin
                // Spare opcodes: no reply and no change.
            end
        endcase
    endtask

    function automatic string reply_text(queue_reply_t r);
        return $sformatf("st=%0d code=%h name=%h_%h pos=%0d occ=%0d last=%b",
                         r.status, r.code, r.nhi, r.nlo, r.pos, r.occ, r.last);
    endfunction

    // Compare the reply on the output bus with the oldest expected one.
    task automatic check_reply();
        queue_reply_t got;
        queue_reply_t want;
        got.status = t_status'(m_axis_tuser);
        got.code   = m_axis_tdata[31:0];
        got.nlo    = m_axis_tdata[95:32];
        got.nhi    = m_axis_tdata[103:96];
        got.pos    = m_axis_tdata[107:104];
        got.occ    = m_axis_tdata[112:108];
        got.last   = m_axis_tlast;
        if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: unexpected reply: %s", $realtime, reply_text(got));
            end
        end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.code !== want.code ||
                got.nlo !== want.nlo || got.nhi !== want.nhi || got.pos !== want.pos ||
                got.occ !== want.occ || got.last !== want.last ||
                m_axis_tdata[119:113] !== 7'd0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: reply mismatch", $realtime);
                    $display("    expected %s", reply_text(want));
                    $display("    actual   %s fill=%h", reply_text(got),
                             m_axis_tdata[119:113]);
                end
            end
        end
    endtask

    // Monitor: sample both streams at the rising edge, predict, check, and watch for hangs.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            predict_queue_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[95:32],
                             s_axis_tdata[103:96]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_reply();
            quiet_cycles = 0;
        end else if (in_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("[fifo_queue_with_search_unit] ERROR");
            $finish;
        end
    end

    // Command driver: offers the backlog at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        queue_cmd_t nxt;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.nhi, nxt.nlo, nxt.code};
                s_axis_tuser  <= nxt.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Reply receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_cmd(logic [2:0] op, logic signed [31:0] code, logic [63:0] nlo,
                            logic [7:0] nhi);
        queue_cmd_t c;
        c.op   = op;
        c.code = code;
        c.nlo  = nlo;
        c.nhi  = nhi;
        cmd_backlog.push_back(c);
    endtask

    // Codes mostly from a small pool so that searches find several matches.
    function automatic logic signed [31:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return $signed($urandom_range(3)) - 1;
        end else if (r < 65) begin
            return 32'sh7FFF_FFFF;
        end else if (r < 70) begin
            return 32'sh8000_0000;
        end
        return $urandom;
    endfunction

    // Random nine-character name; some get a terminator somewhere inside.
    function automatic logic [71:0] pick_name();
        logic [71:0] nm;
        int          cut;
        nm = {8'($urandom_range(255)), $urandom, $urandom};
        if ($urandom_range(99) < 30) begin
            cut = $urandom_range(8);
            nm[8*cut +: 8] = 8'd0;
        end
        return nm;
    endfunction

    function automatic logic [2:0] pick_op(int mode);
        int r;
        r = $urandom_range(99);
        if (r < 2) begin
            return ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        case (mode)
            MODE_FILL:  r = (r < 60) ? 0 : (r < 70) ? 1 : (r < 82) ? 2 : (r < 92) ? 3 : 4;
            MODE_DRAIN: r = (r < 20) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : (r < 90) ? 3 : 4;
            default:    r = (r < 40) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : (r < 90) ? 3 : 4;
        endcase
        r = (r == 0) ? OP_ENQ : (r == 1) ? OP_DEQ : (r == 2) ? OP_SEARCH :
            (r == 3) ? OP_LIST : (($urandom_range(3) == 0) ? OP_CLEAR : OP_SIZE);
        return r[2:0];
    endfunction

    // A burst of count real commands; spare opcodes are extra and not counted.
    task automatic queue_burst(int mode, int count);
        logic [2:0]  op;
        logic [71:0] nm;
        int          made;
        made = 0;
        while (made < count) begin
            op = pick_op(mode);
            nm = pick_name();
            send_cmd(op, pick_code(), nm[63:0], nm[71:64]);
            if (op != OP_SPARE_LO && op != OP_SPARE_HI) begin
                made++;
            end
        end
    endtask

    task automatic random_bursts(int count);
        int n;
        while (count > 0) begin
            n = $urandom_range(10, 30);
            if (n > count) begin
                n = count;
            end
            queue_burst($urandom_range(MODE_MIXED), n);
            count -= n;
        end
    endtask

    // Hold the sender back until every expected reply has been seen.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_axis_tvalid || pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [71:0] nm;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, field extremes, early terminators, clear, spare opcodes.
        send_cmd(OP_DEQ, '0, '0, '0);
        send_cmd(OP_SIZE, '0, '0, '0);
        send_cmd(OP_SEARCH, '0, '0, '0);
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_ENQ, 32'sh7FFF_FFFF, '1, 8'hFF);
        send_cmd(OP_ENQ, 32'sh8000_0000, 64'h4142_4344_0046_4748, 8'h41);
        send_cmd(OP_ENQ, '0, '0, 8'h5A);
        send_cmd(OP_ENQ, -32'sd1, 64'h0102_0304_0506_0708, 8'h00);
        send_cmd(OP_ENQ, 32'sh8000_0000, 64'h0061_6263_6465_6667, 8'hFF);
        send_cmd(OP_SIZE, '0, '0, '0);
        send_cmd(OP_SEARCH, 32'sh8000_0000, '1, 8'hFF);
        send_cmd(OP_SEARCH, 32'sd12345, '0, '0);
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_DEQ, '0, '0, '0);
        send_cmd(OP_SPARE_LO, -32'sd1, '1, 8'hFF);
        send_cmd(OP_SPARE_HI, 32'sd1, 64'h1, 8'h1);
        send_cmd(OP_SEARCH, 32'sh7FFF_FFFF, '0, '0);
        send_cmd(OP_CLEAR, '0, '0, '0);
        send_cmd(OP_SIZE, '0, '0, '0);
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_ENQ, 32'sd7, 64'h5A5A_5A5A_5A5A_5A5A, 8'hA5);
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_DEQ, '0, '0, '0);
        send_cmd(OP_DEQ, '0, '0, '0);

        // Fill past the top so full replies and sixteen-entry walks occur, then random.
        for (int i = 0; i < 18; i++) begin
            nm = pick_name();
            send_cmd(OP_ENQ, pick_code(), nm[63:0], nm[71:64]);
        end
        send_cmd(OP_LIST, '0, '0, '0);
        send_cmd(OP_SEARCH, -32'sd1, '0, '0);
        random_bursts(110);
        wait_drained();

        // Sender mostly idle, receiver mostly busy.
        send_idle_pct = 80;
        recv_idle_pct = 16;
        random_bursts(130);
        wait_drained();

        // No idling; a long receiver hold-off first so the unit backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = ~hold_req;
        queue_burst(MODE_FILL, 40);
        random_bursts(90);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("[fifo_queue_with_search_unit] OK");
        end else begin
            $display("[fifo_queue_with_search_unit] ERROR");
        end
        $finish;
    end

endmodule
